### hw/rtl/grn_pkg.sv
// Shared types, constants and arithmetic helpers for the gated RMS normalizer.
package grn_pkg;

  localparam int SUM_W   = 44;
  localparam int SCALE_W = 24;
  localparam int EPS_W   = 24;
  localparam int DVS_W   = 31;

  localparam logic [EPS_W-1:0]   EPS_RESET = 24'd17;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 24'hFFFFFF;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] sample;
    logic signed [15:0] gate_value;
    logic signed [15:0] gain;
    logic               last;
  } grn_in_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic               end_of_row;
    logic               clipped;
  } grn_out_t;

  // Word as held in the queue between the front and the back.
  typedef struct packed {
    logic               is_apply;
    logic               last;
    logic signed [15:0] sample;
    logic signed [15:0] gate_value;
    logic signed [15:0] gain;
  } grn_item_t;

  typedef struct packed {
    logic               done;
    logic [SCALE_W-1:0] scale;
    logic               clipped;
  } grn_rsq_rsp_t;

  // Piecewise-linear sigmoid in Q.12, mirrored for negative inputs.
  function automatic logic [12:0] sigmoid_q12(input logic signed [15:0] g);
    logic [15:0] a;
    logic [12:0] s;
    a = g[15] ? 16'(-g) : 16'(g);
    if (a >= 16'd20480) begin
      s = 13'd4096;
    end else if (a >= 16'd9728) begin
      s = 13'(a >> 5) + 13'd3456;
    end else if (a >= 16'd4096) begin
      s = 13'(a >> 3) + 13'd2560;
    end else begin
      s = 13'(a >> 2) + 13'd2048;
    end
    return g[15] ? 13'd4096 - s : s;
  endfunction

  // Rounds v / 2^s to nearest with ties away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

### hw/rtl/gated_rms_normalize.sv
// Top level of the gated RMS normalizer: epsilon register, front end and back end.
//
// Input words arrive on in_valid / in_stall / in_data. An accumulate word (opcode 0)
// adds sample squared to the open row; the word marked last closes the row and
// starts the scale unit. An apply word (opcode 1) yields one output word
// result = sample * scale * gain * silu(gate_value) on out_valid / out_stall / out_data.
// The epsilon register is written through cfg_valid / cfg_ready / cfg_data; the user must
// write it only while idle, as the block has no check for it. cfg_ready is always high.
// An accumulate word leaves the back end idle, ready for the next word. An apply word
// passes through the three registered multiplies and the output register, and the back
// end takes no new word until it is done. Closing a row holds the back end while the
// scale unit runs its division, second division and square root one bit per cycle;
// a zero mean plus epsilon ends it after the first division with the scale clipped.
// A two-word queue sits between the front and back; in_stall rises when it is full.
// When the receiver stalls, the output word holds and the next apply result waits for it.
// Reset clears the row sum, count, scale (zero, so apply words give zero),
// the queue and the output valid, and loads epsilon with 17.
module gated_rms_normalize #(
  parameter int MAX_ROW = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  grn_pkg::grn_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output grn_pkg::grn_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [grn_pkg::EPS_W-1:0] cfg_data
);

  logic [grn_pkg::EPS_W-1:0] eps_r;
  logic                      q_valid;
  logic                      q_pop;
  grn_pkg::grn_item_t        q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= grn_pkg::EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  grn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  grn_back #(.MAX_ROW(MAX_ROW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .epsilon   (eps_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/grn_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module grn_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  grn_pkg::grn_in_t   in_data,
  output logic               q_valid,
  output grn_pkg::grn_item_t q_item,
  input  logic               q_pop
);

  grn_pkg::grn_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       pop;
  grn_pkg::grn_item_t item;

  assign in_stall = (fill_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    item.is_apply   = (in_data.opcode == grn_pkg::OP_APPLY);
    item.last       = in_data.last;
    item.sample     = in_data.sample;
    item.gate_value = in_data.gate_value;
    item.gain       = in_data.gain;
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

### hw/rtl/grn_rsqrt.sv
// Iterative row scale unit: mean by long division, then 2^56 / v and an integer square root unless v is zero.
module grn_rsqrt #(
  parameter int CNT_W = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [grn_pkg::SUM_W-1:0]     sum,
  input  logic [CNT_W-1:0]              count,
  input  logic [grn_pkg::EPS_W-1:0]     epsilon,
  output grn_pkg::grn_rsq_rsp_t         rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV1 = 2'd1;
  localparam logic [1:0] ST_DIV2 = 2'd2;
  localparam logic [1:0] ST_SQRT = 2'd3;

  logic [1:0]  st_r;
  logic [5:0]  cnt_r;
  logic [63:0] a_r;
  logic [63:0] q_r;
  logic [63:0] bit_r;
  logic [32:0] rem_r;
  logic [grn_pkg::DVS_W-1:0] dvs_r;
  logic        zero_cnt_r;
  logic        done_r;
  logic [grn_pkg::SCALE_W-1:0] scale_r;
  logic        clip_r;

  logic [32:0] rem_sh;
  logic        div_ge;
  logic [32:0] rem_nxt;
  logic [63:0] dq_nxt;
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [63:0] sq_rem_nxt;
  logic [63:0] root_nxt;
  logic [grn_pkg::DVS_W-1:0] v;

  always_comb begin
    rem_sh  = {rem_r[31:0], a_r[63]};
    div_ge  = rem_sh >= {2'b00, dvs_r};
    rem_nxt = div_ge ? rem_sh - {2'b00, dvs_r} : rem_sh;
    dq_nxt  = {q_r[62:0], div_ge};
    sq_t       = q_r + bit_r;
    sq_ge      = a_r >= sq_t;
    sq_rem_nxt = sq_ge ? a_r - sq_t : a_r;
    root_nxt   = sq_ge ? (q_r >> 1) + bit_r : q_r >> 1;
    // The mean of squares never exceeds 2^30, so the sum with epsilon fits.
    v = (zero_cnt_r ? '0 : dq_nxt[grn_pkg::DVS_W-1:0])
        + grn_pkg::DVS_W'(epsilon);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (start) begin
            st_r       <= ST_DIV1;
            a_r        <= {sum, (64 - grn_pkg::SUM_W)'(0)};
            dvs_r      <= grn_pkg::DVS_W'(count);
            zero_cnt_r <= (count == '0);
            rem_r      <= '0;
            q_r        <= '0;
            cnt_r      <= 6'(grn_pkg::SUM_W - 1);
          end
        end
        ST_DIV1: begin
          a_r   <= a_r << 1;
          rem_r <= rem_nxt;
          q_r   <= dq_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            if (v == '0) begin
              st_r    <= ST_IDLE;
              done_r  <= 1'b1;
              scale_r <= grn_pkg::SCALE_MAX;
              clip_r  <= 1'b1;
            end else begin
              st_r  <= ST_DIV2;
              dvs_r <= v;
              a_r   <= 64'h8000_0000_0000_0000;
              rem_r <= '0;
              q_r   <= '0;
              cnt_r <= 6'd56;
            end
          end
        end
        ST_DIV2: begin
          a_r   <= a_r << 1;
          rem_r <= rem_nxt;
          q_r   <= dq_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            st_r  <= ST_SQRT;
            a_r   <= dq_nxt;
            q_r   <= '0;
            bit_r <= 64'd1 << 62;
            cnt_r <= 6'd31;
          end
        end
        ST_SQRT: begin
          a_r   <= sq_rem_nxt;
          q_r   <= root_nxt;
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            st_r   <= ST_IDLE;
            done_r <= 1'b1;
            if (root_nxt > 64'(grn_pkg::SCALE_MAX)) begin
              scale_r <= grn_pkg::SCALE_MAX;
              clip_r  <= 1'b1;
            end else begin
              scale_r <= root_nxt[grn_pkg::SCALE_W-1:0];
              clip_r  <= 1'b0;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.done    = done_r;
    rsp.scale   = scale_r;
    rsp.clipped = clip_r;
  end

endmodule

### hw/rtl/grn_back.sv
// Back end: accumulates squares, runs the scale unit and computes gated outputs.
module grn_back #(
  parameter int MAX_ROW = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  grn_pkg::grn_item_t        q_item,
  output logic                      q_pop,
  input  logic [grn_pkg::EPS_W-1:0] epsilon,
  output logic                      out_valid,
  input  logic                      out_stall,
  output grn_pkg::grn_out_t         out_data
);

  localparam int CNT_W = $clog2(MAX_ROW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_AP1  = 3'd2;
  localparam logic [2:0] ST_AP2  = 3'd3;
  localparam logic [2:0] ST_AP3  = 3'd4;

  logic [2:0] st_r;
  logic [grn_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [grn_pkg::SCALE_W-1:0] scale_r;
  logic                        sclip_r;
  logic                        rsq_start;
  grn_pkg::grn_rsq_rsp_t       rsp;

  logic signed [40:0] prod1_r;
  logic signed [28:0] silu_r;
  logic signed [15:0] gain_r;
  logic               last_r;
  logic signed [40:0] prod2_r;
  logic signed [56:0] prod3_r;
  logic signed [24:0] t1;
  logic signed [27:0] t2;
  logic signed [63:0] y;
  logic               out_valid_r;
  grn_pkg::grn_out_t  out_r;
  logic               out_free;
  logic signed [31:0] sq;

  grn_rsqrt #(.CNT_W(CNT_W)) u_rsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rsq_start),
    .sum     (sum_nxt),
    .count   (count_nxt),
    .epsilon (epsilon),
    .rsp     (rsp)
  );

  assign q_pop     = (st_r == ST_IDLE) && q_valid;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sq        = q_item.sample * q_item.sample;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (count_r < CNT_W'(MAX_ROW)) begin
      sum_nxt   = sum_r + grn_pkg::SUM_W'(sq);
      count_nxt = count_r + CNT_W'(1);
    end
    rsq_start = q_pop && !q_item.is_apply && q_item.last;
    t1 = 25'(grn_pkg::round_shift(64'(prod1_r), 16));
    t2 = 28'(grn_pkg::round_shift(64'(prod2_r), 12));
    y  = grn_pkg::round_shift(64'(prod3_r), 24);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      scale_r     <= '0;
      sclip_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In the last apply step a taken word is replaced by the new one below.
      if (out_valid_r && !out_stall && st_r != ST_AP3) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_item.is_apply) begin
              st_r <= ST_AP1;
            end else if (q_item.last) begin
              sum_r   <= '0;
              count_r <= '0;
              st_r    <= ST_WAIT;
            end else begin
              sum_r   <= sum_nxt;
              count_r <= count_nxt;
            end
          end
        end
        ST_WAIT: begin
          if (rsp.done) begin
            scale_r <= rsp.scale;
            sclip_r <= rsp.clipped;
            st_r    <= ST_IDLE;
          end
        end
        ST_AP1: st_r <= ST_AP2;
        ST_AP2: st_r <= ST_AP3;
        ST_AP3: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_pop) begin
      prod1_r <= q_item.sample * $signed({1'b0, scale_r});
      silu_r  <= q_item.gate_value * $signed({1'b0, grn_pkg::sigmoid_q12(q_item.gate_value)});
      gain_r  <= q_item.gain;
      last_r  <= q_item.last;
    end
    if (st_r == ST_AP1) begin
      prod2_r <= t1 * gain_r;
    end
    if (st_r == ST_AP2) begin
      prod3_r <= t2 * silu_r;
    end
    if (st_r == ST_AP3 && out_free) begin
      out_r.end_of_row <= last_r;
      if (y > 64'sd32767) begin
        out_r.result  <= 16'sh7FFF;
        out_r.clipped <= 1'b1;
      end else if (y < -64'sd32768) begin
        out_r.result  <= 16'sh8000;
        out_r.clipped <= 1'b1;
      end else begin
        out_r.result  <= y[15:0];
        out_r.clipped <= sclip_r;
      end
    end
  end

endmodule

### hw/rtl/grn_checker.sv
// Port-level checker for the gated RMS normalizer and its bind to the top level.
module grn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input grn_pkg::grn_out_t out_data
);

  // A stalled output word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The queue is empty after reset, so the input side is open.
  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind gated_rms_normalize grn_checker u_grn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
